// ----- hdl/cffp_pkg.sv -----
// Shared constants and types of the command frame field parser.
package cffp_pkg;

    localparam int DEVICE_ID_BYTES = 8;
    localparam int SEQUENCE_BYTES  = 4;
    localparam int ADDRESS_BYTES   = 6;
    localparam int IPV4_BYTES      = 4;
    localparam int LOST_BYTES      = 4;

    localparam int BYTE_W  = 8;
    localparam int FIELD_W = 4;
    localparam int INDEX_W = 16;
    localparam int CFG_IDX_W = 2;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] REG_LOGIN_CODE       = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_KEEPALIVE_CODE   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_PASSTHROUGH_CODE = 2'd2;

    localparam logic [BYTE_W-1:0] LOGIN_CODE_RST       = 8'd1;
    localparam logic [BYTE_W-1:0] KEEPALIVE_CODE_RST   = 8'd2;
    localparam logic [BYTE_W-1:0] PASSTHROUGH_CODE_RST = 8'd3;

    // Parser states; each one tags its byte with the field code of the same value.
    typedef enum logic [FIELD_W-1:0] {
        ST_VER   = 4'd0,
        ST_CMD   = 4'd1,
        ST_LEN   = 4'd2,
        ST_DTYPE = 4'd3,
        ST_DEVID = 4'd4,
        ST_SEQ   = 4'd5,
        ST_PTYPE = 4'd6,
        ST_MAC   = 4'd7,
        ST_IP    = 4'd8,
        ST_LOGIN = 4'd9,
        ST_LOST  = 4'd10,
        ST_DLEN  = 4'd11,
        ST_DATA  = 4'd12
    } t_state;

    typedef enum logic {
        KIND_LOGIN = 1'b0,
        KIND_KEEP  = 1'b1
    } t_kind;

endpackage

// ----- hdl/command_frame_field_parser.sv -----
// Top level of the command frame field parser.
//
// Tags each received frame byte with its field code and its position within that
// field, one result beat per input beat. A byte is accepted in every cycle in
// which the result register is empty or its beat is being taken, so the block
// sustains one byte per cycle while its beats are taken; the only limit is the
// single result register. The command byte is classified against the login,
// keep-alive and pass-through codes (in that order) at the last sequence byte;
// an unknown command ends the frame there and sets o_unknown_command. Code
// registers are written through the configuration channel, which is always ready;
// indexes beyond the three registers are ignored.
module command_frame_field_parser (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_in_valid,
    output logic                            o_in_ready,
    input  logic [cffp_pkg::BYTE_W-1:0]     i_byte_in,
    output logic                            o_out_valid,
    input  logic                            i_out_ready,
    output logic [cffp_pkg::BYTE_W-1:0]     o_byte_out,
    output logic [cffp_pkg::FIELD_W-1:0]    o_field_code,
    output logic [cffp_pkg::INDEX_W-1:0]    o_field_index,
    output logic                            o_frame_end,
    output logic                            o_unknown_command,
    input  logic                            i_cfg_valid,
    output logic                            o_cfg_ready,
    input  logic [cffp_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [cffp_pkg::BYTE_W-1:0]     i_cfg_data
);
    import cffp_pkg::*;

    t_state              r_state, n_state;
    t_kind               r_kind, n_kind;
    logic [INDEX_W-1:0]  r_count, n_count;
    logic [BYTE_W-1:0]   r_command, n_command;
    logic [INDEX_W-1:0]  r_data_length, n_data_length;

    logic [BYTE_W-1:0]   r_login_code, r_keepalive_code, r_passthrough_code;

    logic                r_out_valid;
    logic [BYTE_W-1:0]   r_byte_out;
    logic [FIELD_W-1:0]  r_field_code, n_field_code;
    logic [INDEX_W-1:0]  r_field_index, n_field_index;
    logic                r_frame_end, n_frame_end;
    logic                r_unknown, n_unknown;

    logic                in_fire;
    logic [INDEX_W:0]    count_inc;
    logic [INDEX_W-1:0]  merged_length;

    assign o_in_ready  = !r_out_valid || i_out_ready;
    assign in_fire     = i_in_valid && o_in_ready;
    assign o_cfg_ready = 1'b1;

    assign count_inc     = {1'b0, r_count} + (INDEX_W+1)'(1);
    assign merged_length = r_data_length | {{(INDEX_W-BYTE_W){1'b0}}, i_byte_in};

    always_comb begin
        n_state       = r_state;
        n_kind        = r_kind;
        n_count       = r_count;
        n_command     = r_command;
        n_data_length = r_data_length;
        n_field_code  = FIELD_W'(r_state);
        n_field_index = '0;
        n_frame_end   = 1'b0;
        n_unknown     = 1'b0;
        unique case (r_state)
            ST_CMD: begin
                n_command = i_byte_in;
                n_state   = ST_LEN;
            end
            ST_LEN: begin
                n_state = ST_DTYPE;
            end
            ST_DTYPE: begin
                n_count = '0;
                n_state = ST_DEVID;
            end
            ST_DEVID: begin
                n_field_index = r_count;
                if (count_inc >= (INDEX_W+1)'(DEVICE_ID_BYTES)) begin
                    n_count = '0;
                    n_state = ST_SEQ;
                end else begin
                    n_count = count_inc[INDEX_W-1:0];
                end
            end
            ST_SEQ: begin
                n_field_index = r_count;
                if (count_inc >= (INDEX_W+1)'(SEQUENCE_BYTES)) begin
                    n_count = '0;
                    // Codes are matched in priority order; a shared value takes login first.
                    priority if (r_command == r_login_code) begin
                        n_kind  = KIND_LOGIN;
                        n_state = ST_PTYPE;
                    end else if (r_command == r_keepalive_code) begin
                        n_kind  = KIND_KEEP;
                        n_state = ST_PTYPE;
                    end else if (r_command == r_passthrough_code) begin
                        n_state = ST_DLEN;
                    end else begin
                        n_frame_end = 1'b1;
                        n_unknown   = 1'b1;
                        n_state     = ST_VER;
                    end
                end else begin
                    n_count = count_inc[INDEX_W-1:0];
                end
            end
            ST_PTYPE: begin
                n_count = '0;
                n_state = ST_MAC;
            end
            ST_MAC: begin
                n_field_index = r_count;
                if (count_inc >= (INDEX_W+1)'(ADDRESS_BYTES)) begin
                    n_count = '0;
                    n_state = ST_IP;
                end else begin
                    n_count = count_inc[INDEX_W-1:0];
                end
            end
            ST_IP: begin
                n_field_index = r_count;
                if (count_inc >= (INDEX_W+1)'(IPV4_BYTES)) begin
                    n_count = '0;
                    n_state = (r_kind == KIND_LOGIN) ? ST_LOGIN : ST_LOST;
                end else begin
                    n_count = count_inc[INDEX_W-1:0];
                end
            end
            ST_LOGIN: begin
                n_frame_end = 1'b1;
                n_count     = '0;
                n_state     = ST_VER;
            end
            ST_LOST: begin
                n_field_index = r_count;
                if (count_inc >= (INDEX_W+1)'(LOST_BYTES)) begin
                    n_frame_end = 1'b1;
                    n_count     = '0;
                    n_state     = ST_VER;
                end else begin
                    n_count = count_inc[INDEX_W-1:0];
                end
            end
            ST_DLEN: begin
                n_field_index = r_count;
                // The length arrives high byte first.
                if (r_count == '0) begin
                    n_data_length = {i_byte_in, {(INDEX_W-BYTE_W){1'b0}}};
                    n_count       = INDEX_W'(1);
                end else begin
                    n_data_length = merged_length;
                    n_count       = '0;
                    if (merged_length == '0) begin
                        n_frame_end = 1'b1;
                        n_state     = ST_VER;
                    end else begin
                        n_state = ST_DATA;
                    end
                end
            end
            ST_DATA: begin
                n_field_index = r_count;
                if (count_inc >= {1'b0, r_data_length}) begin
                    n_frame_end = 1'b1;
                    n_count     = '0;
                    n_state     = ST_VER;
                end else begin
                    n_count = count_inc[INDEX_W-1:0];
                end
            end
            default: begin
                // Version byte, and any stray state code, starts a new frame.
                n_field_code = FIELD_W'(ST_VER);
                n_count      = '0;
                n_state      = ST_CMD;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= ST_VER;
            r_kind        <= KIND_LOGIN;
            r_count       <= '0;
            r_command     <= '0;
            r_data_length <= '0;
        end else if (in_fire) begin
            r_state       <= n_state;
            r_kind        <= n_kind;
            r_count       <= n_count;
            r_command     <= n_command;
            r_data_length <= n_data_length;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_login_code       <= LOGIN_CODE_RST;
            r_keepalive_code   <= KEEPALIVE_CODE_RST;
            r_passthrough_code <= PASSTHROUGH_CODE_RST;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                REG_LOGIN_CODE:       r_login_code       <= i_cfg_data;
                REG_KEEPALIVE_CODE:   r_keepalive_code   <= i_cfg_data;
                REG_PASSTHROUGH_CODE: r_passthrough_code <= i_cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (in_fire) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_byte_out    <= i_byte_in;
            r_field_code  <= n_field_code;
            r_field_index <= n_field_index;
            r_frame_end   <= n_frame_end;
            r_unknown     <= n_unknown;
        end
    end

    assign o_out_valid       = r_out_valid;
    assign o_byte_out        = r_byte_out;
    assign o_field_code      = r_field_code;
    assign o_field_index     = r_field_index;
    assign o_frame_end       = r_frame_end;
    assign o_unknown_command = r_unknown;

    a_unknown_ends_seq: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_unknown) |->
            (r_frame_end && r_field_code == FIELD_W'(ST_SEQ)))
        else $error("unknown command flagged outside a final sequence beat");

    a_end_restarts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_fire && n_frame_end) |=> (r_state == ST_VER && r_count == '0))
        else $error("frame end did not return the parser to the version byte");

    a_data_len_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_DATA) |-> (r_data_length != '0 && r_count < r_data_length))
        else $error("data state with an exhausted or zero length");

    a_devid_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_DEVID) |-> (r_count < INDEX_W'(DEVICE_ID_BYTES)))
        else $error("device id position out of range");

endmodule
